[hdl/jse_pkg.sv]
package jse_pkg;

   localparam int MAX_PEOPLE = 4096;
   localparam int ADDR_W     = $clog2(MAX_PEOPLE);
   localparam int CNT_W      = 13;
   localparam int STEP_W     = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD,
      ST_WALK,
      ST_HOP,
      ST_SPLICE,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic              ren;
      logic [ADDR_W-1:0] raddr;
      logic              wen;
      logic [ADDR_W-1:0] waddr;
      logic [ADDR_W-1:0] wdata;
   } ram_cmd_type;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] survivor;
   } done_type;

endpackage

[hdl/jse_ring_ram.sv]
module jse_ring_ram (
   input  logic                          clock,
   input  jse_pkg::ram_cmd_type          cmd,
   output logic [jse_pkg::ADDR_W-1:0]    rdata
);
   import jse_pkg::*;

   logic [ADDR_W-1:0] mem [MAX_PEOPLE];
   logic [ADDR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wen) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ren) begin
         rdata_ff <= mem[cmd.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/jse_walk_ctrl.sv]
module jse_walk_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [jse_pkg::CNT_W-1:0]     req_count,
   input  logic [jse_pkg::STEP_W-1:0]    req_step,
   output logic                          req_ready,
   output jse_pkg::ram_cmd_type          ram_cmd,
   input  logic [jse_pkg::ADDR_W-1:0]    ram_rdata,
   output jse_pkg::done_type             done,
   input  logic                          done_taken
);
   import jse_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] hops_ff, hops_in;
   logic [CNT_W-1:0]  remaining_ff, remaining_in;
   logic [CNT_W-1:0]  count_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remaining_ff <= '0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      idx_ff  <= idx_in;
      cur_ff  <= cur_in;
      step_ff <= step_in;
      hops_ff <= hops_in;
   end

   // clamp the count into 1..MAX_PEOPLE
   always_comb begin
      if (req_count == '0) begin
         count_sat = CNT_W'(1);
      end else if (req_count > CNT_W'(MAX_PEOPLE)) begin
         count_sat = CNT_W'(MAX_PEOPLE);
      end else begin
         count_sat = req_count;
      end
   end

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      hops_in      = hops_ff;
      remaining_in = remaining_ff;
      req_ready    = 1'b0;
      ram_cmd      = '0;
      done.valid   = 1'b0;
      done.survivor = CNT_W'(cur_ff) + CNT_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               last_in  = ADDR_W'(count_sat - CNT_W'(1));
               step_in  = (req_step == '0) ? STEP_W'(1) : req_step;
               idx_in   = '0;
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            // link each position to the one after it, the last back to the first
            ram_cmd.wen   = 1'b1;
            ram_cmd.waddr = idx_ff;
            ram_cmd.wdata = (idx_ff == last_ff) ? '0 : idx_ff + ADDR_W'(1);
            idx_in        = idx_ff + ADDR_W'(1);
            if (idx_ff == last_ff) begin
               cur_in       = last_ff;
               remaining_in = CNT_W'(last_ff) + CNT_W'(1);
               hops_in      = step_ff - STEP_W'(1);
               state_in     = (last_ff == '0) ? ST_FINISH : ST_WALK;
            end
         end
         ST_WALK: begin
            ram_cmd.ren   = 1'b1;
            ram_cmd.raddr = cur_ff;
            state_in      = ST_HOP;
         end
         ST_HOP: begin
            // follow the link just read; the final read yields the victim's successor
            ram_cmd.ren   = 1'b1;
            ram_cmd.raddr = ram_rdata;
            if (hops_ff != '0) begin
               cur_in  = ram_rdata;
               hops_in = hops_ff - STEP_W'(1);
            end else begin
               state_in = ST_SPLICE;
            end
         end
         ST_SPLICE: begin
            // unlink the victim
            ram_cmd.wen   = 1'b1;
            ram_cmd.waddr = cur_ff;
            ram_cmd.wdata = ram_rdata;
            remaining_in  = remaining_ff - CNT_W'(1);
            hops_in       = step_ff - STEP_W'(1);
            state_in      = (remaining_ff == CNT_W'(2)) ? ST_FINISH : ST_WALK;
         end
         ST_FINISH: begin
            done.valid = 1'b1;
            if (done_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/josephus_survivor_engine_core.sv]
// Channel   Direction  Payload
// req_*     in         tdata[12:0] people_count, tdata[28:13] step_interval
// rsp_*     out        tdata[12:0] survivor
//
// An item first links the ring, then for each removal does one walk read,
// one read per link and one splice write; the chain of dependent reads
// through the ring memory, one link per cycle, sets the pace of the walk.
// reset is synchronous; the ring memory is not cleared, each item rewrites it.
// A new item is taken while a result waits on rsp_; a finished result holds
// in the engine until the output register is free.
module josephus_survivor_engine_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [12:0] people_count, [28:13] step_interval, [31:29] zero
   input  logic [jse_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [12:0] survivor, [15:13] zero
   output logic [jse_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import jse_pkg::*;

   ram_cmd_type       ram_cmd;
   logic [ADDR_W-1:0] ram_rdata;
   done_type          done;
   logic              done_taken;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_survivor_ff, rsp_survivor_in;

   jse_ring_ram u_ring_ram (
      .clock (clock),
      .cmd   (ram_cmd),
      .rdata (ram_rdata)
   );

   jse_walk_ctrl u_walk_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_count  (req_tdata[CNT_W-1:0]),
      .req_step   (req_tdata[CNT_W+STEP_W-1:CNT_W]),
      .req_ready  (req_tready),
      .ram_cmd    (ram_cmd),
      .ram_rdata  (ram_rdata),
      .done       (done),
      .done_taken (done_taken)
   );

   // take the result once the output register is empty or draining
   assign done_taken = done.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_survivor_in = rsp_survivor_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_taken) begin
         rsp_valid_in    = 1'b1;
         rsp_survivor_in = done.survivor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_survivor_ff <= rsp_survivor_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-CNT_W)'(0), rsp_survivor_ff};

endmodule
